[sv/dht_pkg.sv]
// ----------------------------------------------------------------------------
// dht_pkg: shared types and constants for the direction hysteresis tracker
// Word layouts, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package dht_pkg;

  // number of tracked slots
  localparam int SLOTS     = 8;
  localparam int SLOT_IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // field widths
  localparam int SLOT_W = 3;
  localparam int ANG_W  = 9;
  localparam int STR_W  = 32;
  localparam int CNT_W  = 8;
  localparam int CFGI_W = 2;

  // angles that mark a candidate as bogus
  localparam logic [ANG_W-1:0] AZ_ZERO = ANG_W'(0);
  localparam logic [ANG_W-1:0] AZ_HALF = ANG_W'(180);

  // miss counter saturation
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // configuration register indexes
  localparam logic [CFGI_W-1:0] CFG_ENERGY_FLOOR    = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_ZERO_FLOOR      = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_ANGLE_TOLERANCE = 2'd2;
  localparam logic [CFGI_W-1:0] CFG_CONFIRM_COUNT   = 2'd3;

  // configuration reset values
  localparam logic [STR_W-1:0] RST_ENERGY_FLOOR    = '0;
  localparam logic [STR_W-1:0] RST_ZERO_FLOOR      = '0;
  localparam logic [ANG_W-1:0] RST_ANGLE_TOLERANCE = ANG_W'(15);
  localparam logic [CNT_W-1:0] RST_CONFIRM_COUNT   = CNT_W'(3);

  // one input candidate word
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [ANG_W-1:0]  azimuth;
    logic [ANG_W-1:0]  elevation;
    logic [STR_W-1:0]  strength;
    logic              batch_end;
  } dht_item_t;

  // configuration register set
  typedef struct packed {
    logic [STR_W-1:0] energy_floor;
    logic [STR_W-1:0] zero_floor;
    logic [ANG_W-1:0] angle_tolerance;
    logic [CNT_W-1:0] confirm_count;
  } dht_cfg_t;

  // one report word
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [ANG_W-1:0]  azimuth;
    logic [ANG_W-1:0]  elevation;
  } dht_res_t;

  // tracker status toward the top level
  typedef struct packed {
    logic     produce;
    logic     first_batch;
    dht_res_t res;
  } dht_trk_t;

endpackage

[sv/dht_in_reg.sv]
// ----------------------------------------------------------------------------
// dht_in_reg: input register stage
// Captures one candidate word and holds it until the tracking stage moves on.
// ----------------------------------------------------------------------------
module dht_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dht_pkg::dht_item_t in_word,
  input  logic              advance,
  output logic              s1_valid,
  output dht_pkg::dht_item_t s1_word
);

  logic               valid_r, valid_nxt;
  dht_pkg::dht_item_t word_r;

  // stage is free when empty or draining this cycle
  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word_r <= in_word;
    end
  end

  assign s1_valid = valid_r;
  assign s1_word  = word_r;

endmodule

[sv/dht_track.sv]
// ----------------------------------------------------------------------------
// dht_track: per-slot hysteresis state and update logic
// Holds azimuth and miss count per slot plus the first-batch flag.
// ----------------------------------------------------------------------------
module dht_track (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  dht_pkg::dht_item_t item,
  input  dht_pkg::dht_cfg_t  cfg,
  output dht_pkg::dht_trk_t  trk
);

  logic [dht_pkg::ANG_W-1:0] held_r [dht_pkg::SLOTS];
  logic [dht_pkg::CNT_W-1:0] miss_r [dht_pkg::SLOTS];
  logic                      first_r, first_nxt;

  logic [dht_pkg::SLOT_IDXW-1:0] idx;
  logic                          in_range;
  logic                          cand_ok;
  logic [dht_pkg::ANG_W-1:0]     held;
  logic [dht_pkg::CNT_W-1:0]     miss;
  logic [dht_pkg::ANG_W-1:0]     diff;
  logic [dht_pkg::CNT_W-1:0]     miss_step;
  logic                          adopt;
  logic [dht_pkg::ANG_W-1:0]     held_nxt;
  logic [dht_pkg::CNT_W-1:0]     miss_nxt;

  assign idx      = dht_pkg::SLOT_IDXW'(item.slot);
  assign in_range = 32'(item.slot) < dht_pkg::SLOTS;
  assign held     = held_r[idx];
  assign miss     = miss_r[idx];

  // candidate qualification
  assign cand_ok = (item.strength > cfg.energy_floor)
                && !(item.strength < cfg.zero_floor)
                && (item.azimuth != dht_pkg::AZ_ZERO)
                && (item.azimuth != dht_pkg::AZ_HALF);

  // plain absolute difference, no wrap
  assign diff = (item.azimuth > held) ? (item.azimuth - held) : (held - item.azimuth);

  // miss count with saturation, then confirm check
  always_comb begin
    if (diff > cfg.angle_tolerance) begin
      miss_step = (miss == dht_pkg::CNT_MAX) ? miss : miss + 1'b1;
    end else begin
      miss_step = '0;
    end
    adopt = miss_step >= cfg.confirm_count;
  end

  // next slot state
  always_comb begin
    held_nxt = held;
    miss_nxt = miss;
    if (!cand_ok) begin
      miss_nxt = '0;
    end else if (first_r) begin
      held_nxt = item.azimuth;
    end else if (adopt) begin
      held_nxt = item.azimuth;
      miss_nxt = '0;
    end else begin
      miss_nxt = miss_step;
    end
  end

  // batch end closes the first batch
  assign first_nxt = (step && item.batch_end) ? 1'b0 : first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
      for (int k = 0; k < dht_pkg::SLOTS; k++) begin
        held_r[k] <= '0;
        miss_r[k] <= '0;
      end
    end else begin
      first_r <= first_nxt;
      if (step && in_range) begin
        held_r[idx] <= held_nxt;
        miss_r[idx] <= miss_nxt;
      end
    end
  end

  // report
  assign trk.produce       = in_range && cand_ok;
  assign trk.first_batch   = first_r;
  assign trk.res.slot      = item.slot;
  assign trk.res.azimuth   = held_nxt;
  assign trk.res.elevation = item.elevation;

endmodule

[sv/direction_hysteresis_tracker.sv]
// ----------------------------------------------------------------------------
// direction_hysteresis_tracker: top level
// Input register, per-slot tracking, output register and config registers.
// ----------------------------------------------------------------------------
// Path: input register, tracking logic, output register; out_valid rises once a word reaches the output register.
// Throughput: one candidate word per cycle while the output register is free or
//   being taken; the slot state is read and written in the same stage, so back-to-back words to one slot need no stall.
// Rejected or out-of-range words leave the pipe with no result.
// Reset (rst_n low, synchronous): pipe empties, slot state clears, first
//   batch flag sets, config registers return to their defaults.
module direction_hysteresis_tracker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dht_pkg::SLOT_W-1:0]  in_slot,
  input  logic [dht_pkg::ANG_W-1:0]   in_azimuth_in,
  input  logic [dht_pkg::ANG_W-1:0]   in_elevation_in,
  input  logic [dht_pkg::STR_W-1:0]   in_strength,
  input  logic                        in_batch_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dht_pkg::SLOT_W-1:0]  out_slot_out,
  output logic [dht_pkg::ANG_W-1:0]   out_azimuth_out,
  output logic [dht_pkg::ANG_W-1:0]   out_elevation_out,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [dht_pkg::CFGI_W-1:0]  cfg_index,
  input  logic [dht_pkg::STR_W-1:0]   cfg_data
);

  dht_pkg::dht_item_t in_word;
  dht_pkg::dht_item_t s1_word;
  logic               s1_valid;
  logic               s1_go;
  dht_pkg::dht_trk_t  trk;
  dht_pkg::dht_cfg_t  cfg_r, cfg_nxt;
  logic               out_valid_r, out_valid_nxt;
  dht_pkg::dht_res_t  out_res_r;

  assign in_word.slot      = in_slot;
  assign in_word.azimuth   = in_azimuth_in;
  assign in_word.elevation = in_elevation_in;
  assign in_word.strength  = in_strength;
  assign in_word.batch_end = in_batch_end;

  // stage 1 moves when the output register is free or being taken
  assign s1_go = !out_valid_r || out_ready;

  dht_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .advance  (s1_go),
    .s1_valid (s1_valid),
    .s1_word  (s1_word)
  );

  dht_track u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_valid && s1_go),
    .item  (s1_word),
    .cfg   (cfg_r),
    .trk   (trk)
  );

  // configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        dht_pkg::CFG_ENERGY_FLOOR:    cfg_nxt.energy_floor    = cfg_data;
        dht_pkg::CFG_ZERO_FLOOR:      cfg_nxt.zero_floor      = cfg_data;
        dht_pkg::CFG_ANGLE_TOLERANCE: cfg_nxt.angle_tolerance = cfg_data[dht_pkg::ANG_W-1:0];
        dht_pkg::CFG_CONFIRM_COUNT:   cfg_nxt.confirm_count   = cfg_data[dht_pkg::CNT_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.energy_floor    <= dht_pkg::RST_ENERGY_FLOOR;
      cfg_r.zero_floor      <= dht_pkg::RST_ZERO_FLOOR;
      cfg_r.angle_tolerance <= dht_pkg::RST_ANGLE_TOLERANCE;
      cfg_r.confirm_count   <= dht_pkg::RST_CONFIRM_COUNT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // output register
  assign out_valid_nxt = s1_go ? (s1_valid && trk.produce) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_valid && trk.produce) begin
      out_res_r <= trk.res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_slot_out      = out_res_r.slot;
  assign out_azimuth_out   = out_res_r.azimuth;
  assign out_elevation_out = out_res_r.elevation;

  // a blocked full pipe takes no new word
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input accepted while pipe is blocked");

  // a batch end passing the tracker closes the first batch
  a_batch_close: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && s1_go && s1_word.batch_end) |=> !trk.first_batch)
    else $error("first batch flag survived a batch end");

  // the first batch never reopens without reset
  a_first_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !trk.first_batch |=> !trk.first_batch)
    else $error("first batch flag set again");

endmodule

[tb/tb_direction_hysteresis_tracker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_direction_hysteresis_tracker: self-checking bench for the tracker
// Drives candidate words through valid/ready, programs the four registers
// between phases, predicts each report in a local slot model and checks the
// report stream in order, under random gaps, stalls and a long output hold.
// ----------------------------------------------------------------------------
module tb_direction_hysteresis_tracker;

  localparam int DRAIN_CYCLES = 8;     // pipe is two deep, leave some margin
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int IDLE_LIMIT   = 2000;  // watchdog: cycles with no transfer
  localparam int PHASE_ITEMS  = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [dht_pkg::SLOT_W-1:0]   in_slot = '0;
  logic [dht_pkg::ANG_W-1:0]    in_azimuth_in = '0;
  logic [dht_pkg::ANG_W-1:0]    in_elevation_in = '0;
  logic [dht_pkg::STR_W-1:0]    in_strength = '0;
  logic                         in_batch_end = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [dht_pkg::SLOT_W-1:0]   out_slot_out;
  logic [dht_pkg::ANG_W-1:0]    out_azimuth_out;
  logic [dht_pkg::ANG_W-1:0]    out_elevation_out;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [dht_pkg::CFGI_W-1:0]   cfg_index = '0;
  logic [dht_pkg::STR_W-1:0]    cfg_data = '0;

  direction_hysteresis_tracker u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_slot           (in_slot),
    .in_azimuth_in     (in_azimuth_in),
    .in_elevation_in   (in_elevation_in),
    .in_strength       (in_strength),
    .in_batch_end      (in_batch_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_slot_out      (out_slot_out),
    .out_azimuth_out   (out_azimuth_out),
    .out_elevation_out (out_elevation_out),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // local copy of the tracker: registers and per-slot state
  logic [dht_pkg::STR_W-1:0] m_energy_floor;
  logic [dht_pkg::STR_W-1:0] m_zero_floor;
  logic [dht_pkg::ANG_W-1:0] m_angle_tol;
  logic [dht_pkg::CNT_W-1:0] m_confirm;
  logic [dht_pkg::ANG_W-1:0] m_held [dht_pkg::SLOTS];
  logic [dht_pkg::CNT_W-1:0] m_miss [dht_pkg::SLOTS];
  bit                        m_first_batch;

  dht_pkg::dht_res_t pending_reports [$];
  int unsigned       mismatch_count = 0;

  // idling knobs and hold-off request
  int unsigned send_gap_pct = 0;
  int unsigned ready_stall_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;

  // stimulus-side direction each slot is drifting around
  int aim [dht_pkg::SLOTS];

  // one candidate through the slot model; returns 1 when it yields a report
  function automatic bit track_candidate(input dht_pkg::dht_item_t c,
                                         output dht_pkg::dht_res_t r);
    logic [dht_pkg::ANG_W-1:0] h;
    logic [dht_pkg::ANG_W-1:0] diff;
    bit ok;
    bit emit;
    emit = 1'b0;
    r = '0;
    if (int'(c.slot) < dht_pkg::SLOTS) begin
      ok = (c.strength > m_energy_floor) && !(c.strength < m_zero_floor) &&
           (c.azimuth != dht_pkg::AZ_ZERO) && (c.azimuth != dht_pkg::AZ_HALF);
      if (!ok) begin
        m_miss[c.slot] = '0;
      end else begin
        if (m_first_batch) begin
          m_held[c.slot] = c.azimuth;
        end else begin
          h = m_held[c.slot];
          diff = (c.azimuth > h) ? (c.azimuth - h) : (h - c.azimuth);
          if (diff > m_angle_tol) begin
            if (m_miss[c.slot] != dht_pkg::CNT_MAX) m_miss[c.slot] = m_miss[c.slot] + 1'b1;
          end else begin
            m_miss[c.slot] = '0;
          end
          // enough misses in a row: adopt the new direction
          if (m_miss[c.slot] >= m_confirm) begin
            m_held[c.slot] = c.azimuth;
            m_miss[c.slot] = '0;
          end
        end
        r.slot      = c.slot;
        r.azimuth   = m_held[c.slot];
        r.elevation = c.elevation;
        emit        = 1'b1;
      end
    end
    if (c.batch_end) m_first_batch = 1'b0;
    return emit;
  endfunction

  function automatic dht_pkg::dht_item_t cand(input int sl, input int az, input int el,
                                              input logic [dht_pkg::STR_W-1:0] str,
                                              input bit last);
    dht_pkg::dht_item_t c;
    c.slot      = dht_pkg::SLOT_W'(sl);
    c.azimuth   = dht_pkg::ANG_W'(az);
    c.elevation = dht_pkg::ANG_W'(el);
    c.strength  = str;
    c.batch_end = last;
    return c;
  endfunction

  // random candidate: mostly near the slot's drifting direction
  function automatic dht_pkg::dht_item_t make_candidate(input bit last);
    dht_pkg::dht_item_t c;
    int sl;
    int a;
    int d;
    int tol;
    int pick;
    logic [dht_pkg::STR_W-1:0] thr;
    sl = $urandom_range(dht_pkg::SLOTS - 1);
    tol = int'(m_angle_tol);
    c.slot = dht_pkg::SLOT_W'(sl);

    if ($urandom_range(99) < 8) aim[sl] = $urandom_range(359, 1);
    pick = $urandom_range(99);
    if (pick < 60) begin
      a = aim[sl] + int'($urandom_range(2 * tol)) - tol;
    end else if (pick < 80) begin
      d = tol + 1 + int'($urandom_range(40));
      a = ($urandom_range(1) != 0) ? aim[sl] + d : aim[sl] - d;
    end else if (pick < 85) begin
      a = int'(dht_pkg::AZ_ZERO);
    end else if (pick < 89) begin
      a = int'(dht_pkg::AZ_HALF);
    end else if (pick < 94) begin
      a = 360 + int'($urandom_range(151));
    end else begin
      a = $urandom_range(511);
    end
    c.azimuth = dht_pkg::ANG_W'(a);

    c.elevation = ($urandom_range(99) < 25) ? dht_pkg::ANG_W'($urandom_range(511))
                                            : dht_pkg::ANG_W'($urandom_range(359));

    // strength: mostly above both floors, sometimes right at the edges
    pick = $urandom_range(99);
    if (pick < 8) begin
      c.strength = m_energy_floor;
    end else if (pick < 12) begin
      c.strength = (m_zero_floor != '0) ? m_zero_floor - 1'b1 : '0;
    end else if (pick < 18) begin
      c.strength = $urandom;
    end else if (pick < 21) begin
      c.strength = '0;
    end else if (pick < 24) begin
      c.strength = '1;
    end else if (m_energy_floor == '1) begin
      c.strength = $urandom;
    end else begin
      thr = (m_energy_floor >= m_zero_floor) ? m_energy_floor + 1'b1 : m_zero_floor;
      c.strength = thr + $urandom_range(32'hFFFF_FFFF - thr);
    end

    c.batch_end = last || ($urandom_range(99) < 5);
    return c;
  endfunction

  // send one word, with optional idle cycles ahead of it
  task automatic send_word(input dht_pkg::dht_item_t c);
    dht_pkg::dht_res_t r;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_slot         <= c.slot;
    in_azimuth_in   <= c.azimuth;
    in_elevation_in <= c.elevation;
    in_strength     <= c.strength;
    in_batch_end    <= c.batch_end;
    do @(posedge clk); while (!in_ready);
    if (track_candidate(c, r)) pending_reports.push_back(r);
  endtask

  // stop offering, wait for every report, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // program all four registers, in index order
  task automatic set_config(input logic [dht_pkg::STR_W-1:0] ef,
                            input logic [dht_pkg::STR_W-1:0] zf,
                            input logic [dht_pkg::ANG_W-1:0] tol,
                            input logic [dht_pkg::CNT_W-1:0] cc);
    logic [dht_pkg::CFGI_W-1:0] idx [4];
    logic [dht_pkg::STR_W-1:0]  val [4];
    idx[0] = dht_pkg::CFG_ENERGY_FLOOR;    val[0] = ef;
    idx[1] = dht_pkg::CFG_ZERO_FLOOR;      val[1] = zf;
    idx[2] = dht_pkg::CFG_ANGLE_TOLERANCE; val[2] = dht_pkg::STR_W'(tol);
    idx[3] = dht_pkg::CFG_CONFIRM_COUNT;   val[3] = dht_pkg::STR_W'(cc);
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
      case (idx[k])
        dht_pkg::CFG_ENERGY_FLOOR:    m_energy_floor = val[k];
        dht_pkg::CFG_ZERO_FLOOR:      m_zero_floor   = val[k];
        dht_pkg::CFG_ANGLE_TOLERANCE: m_angle_tol    = val[k][dht_pkg::ANG_W-1:0];
        dht_pkg::CFG_CONFIRM_COUNT:   m_confirm      = val[k][dht_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // first batch after reset: loads, rejects, batch end on a rejected word
  task automatic test_first_batch();
    send_word(cand(0,  90,  10, 32'h0001_0000, 1'b0));
    send_word(cand(7, 359, 359, 32'hFFFF_FFFF, 1'b0));
    send_word(cand(1,   0,   5, 32'h0001_0000, 1'b0));
    send_word(cand(2, 180,   5, 32'h0001_0000, 1'b0));
    send_word(cand(3,  45,   5, 32'h0000_0000, 1'b0));
    send_word(cand(4, 511, 511, 32'h0000_0001, 1'b0));
    send_word(cand(5,   1,   0, 32'h0000_0000, 1'b1));
  endtask

  // default tolerance and confirm count: misses, clears, adoption, no wrap
  task automatic test_hysteresis();
    send_word(cand(0, 105, 20, 32'h0002_0000, 1'b0));  // exactly at tolerance
    send_word(cand(0, 106, 21, 32'h0002_0000, 1'b0));
    send_word(cand(0, 200, 22, 32'h0002_0000, 1'b0));
    send_word(cand(0,   0, 23, 32'h0002_0000, 1'b0));  // reject clears misses
    send_word(cand(0, 200, 24, 32'h0002_0000, 1'b0));
    send_word(cand(0, 200, 25, 32'h0002_0000, 1'b0));
    send_word(cand(0, 200, 26, 32'h0002_0000, 1'b0));  // adopts
    send_word(cand(4, 400, 27, 32'h8000_0000, 1'b0));
    send_word(cand(7,   1, 28, 32'h7FFF_FFFF, 1'b0));
    send_word(cand(6, 300, 29, 32'h5555_AAAA, 1'b1));
  endtask

  // floors and counts at their extremes, confirm count zero included
  task automatic test_config_extremes();
    settle();
    set_config(32'hFFFF_FFFF, 32'h0, 9'd15, 8'd3);
    send_word(cand(0, 200, 30, 32'hFFFF_FFFF, 1'b0));
    settle();
    set_config(32'h0, 32'hFFFF_FFFF, 9'd511, 8'd0);
    send_word(cand(1,  50, 31, 32'hFFFF_FFFF, 1'b0));
    send_word(cand(1,  60, 32, 32'hFFFF_FFFE, 1'b0));
    settle();
    set_config(32'h0, 32'h0, 9'd0, 8'd1);
    send_word(cand(1,  51, 33, 32'h0000_0001, 1'b0));
    send_word(cand(1,  51, 34, 32'h0000_0001, 1'b1));
  endtask

  // random batches: well-formed runs of candidates ending with batch end
  task automatic run_batches(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(8, 1);
      for (int k = 0; k < len; k++) begin
        send_word(make_candidate(k == len - 1));
        sent++;
      end
    end
  endtask

  // several register settings, each under one of four idling patterns
  task automatic test_random_phases();
    logic [dht_pkg::STR_W-1:0] ef;
    logic [dht_pkg::STR_W-1:0] zf;
    logic [dht_pkg::ANG_W-1:0] tol;
    logic [dht_pkg::CNT_W-1:0] cc;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin ef = 32'h0; zf = 32'h0; tol = 9'd15; cc = 8'd3; end
        1: begin ef = 32'h0001_0000; zf = 32'h0000_8000; tol = 9'd5; cc = 8'd2; end
        2: begin
          ef  = $urandom_range(32'h7FFF_FFFF);
          zf  = $urandom_range(32'h7FFF_FFFF);
          tol = dht_pkg::ANG_W'($urandom_range(360));
          cc  = dht_pkg::CNT_W'($urandom_range(6, 1));
        end
        3: begin ef = 32'h0; zf = 32'h0; tol = 9'd0; cc = 8'd1; end
        4: begin ef = 32'h0000_0001; zf = 32'hFFFF_0000; tol = 9'd360; cc = 8'd255; end
        default: begin ef = $urandom_range(32'h00FF_FFFF); zf = 32'h0; tol = 9'd30; cc = 8'd4; end
      endcase
      settle();
      set_config(ef, zf, tol, cc);
      case (p % 4)
        0: begin send_gap_pct = 0;  ready_stall_pct = 0;  end
        1: begin send_gap_pct = 72; ready_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  ready_stall_pct = 72; end
        default: begin send_gap_pct = 36; ready_stall_pct = 36; end
      endcase
      run_batches(PHASE_ITEMS);
    end
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    settle();
    set_config(32'h0, 32'h0, 9'd20, 8'd2);
    send_gap_pct = 0;
    ready_stall_pct = 0;
    hold_req = 1'b1;
    run_batches(80);
  endtask

  // receiver: random stalls, or a counted hold-off when requested
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  // report checker: in order against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected report: slot %0d az %0d el %0d",
                   out_slot_out, out_azimuth_out, out_elevation_out);
        mismatch_count++;
      end else if (pending_reports[0].slot != out_slot_out ||
                   pending_reports[0].azimuth != out_azimuth_out ||
                   pending_reports[0].elevation != out_elevation_out) begin
        if (mismatch_count < 10)
          $display("report mismatch: exp slot %0d az %0d el %0d, got slot %0d az %0d el %0d",
                   pending_reports[0].slot, pending_reports[0].azimuth,
                   pending_reports[0].elevation,
                   out_slot_out, out_azimuth_out, out_elevation_out);
        mismatch_count++;
        void'(pending_reports.pop_front());
      end else begin
        void'(pending_reports.pop_front());
      end
    end
  end

  // watchdog: too long without any word moving on any channel
  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** direction_hysteresis_tracker: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    // model reset state
    m_energy_floor = dht_pkg::RST_ENERGY_FLOOR;
    m_zero_floor   = dht_pkg::RST_ZERO_FLOOR;
    m_angle_tol    = dht_pkg::RST_ANGLE_TOLERANCE;
    m_confirm      = dht_pkg::RST_CONFIRM_COUNT;
    m_first_batch  = 1'b1;
    for (int k = 0; k < dht_pkg::SLOTS; k++) begin
      m_held[k] = '0;
      m_miss[k] = '0;
      aim[k]    = $urandom_range(359, 1);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_first_batch();
    test_hysteresis();
    test_config_extremes();
    test_random_phases();
    test_backpressure();
    settle();

    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("** direction_hysteresis_tracker: PASSED **");
    end else begin
      $display("** direction_hysteresis_tracker: FAILED **");
    end
    $finish;
  end

endmodule
